>>> hdl/mutex_table_with_wait_queues_assert.svh
// Assertion macros shared by the lock table RTL.
`ifndef MUTEX_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH
`define MUTEX_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mtwq_pkg.sv
// Types and codes of the lock table with wait queues.
`timescale 1ns / 1ps

package mtwq_pkg;

    // request kinds carried in tuser
    localparam logic [1:0] KIND_OPEN    = 2'd0;
    localparam logic [1:0] KIND_ACQUIRE = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BLOCKED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_QREAD,
        S_LINK,
        S_DONE
    } t_state;

    // result item, status in the lowest bits
    typedef struct packed {
        logic [3:0] woken_task;
        logic       woken_valid;
        logic [3:0] index_out;
        logic [1:0] status;
    } t_result;

endpackage

>>> hdl/mutex_table_with_wait_queues.sv
// Lock table with per-lock FIFO wait queues, kept in synchronous memories.
//
// Channel  | Dir | Transfer fields (lowest bits first)
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | tuser: kind[1:0]; tdata: lock_key[31:0], lock_index[35:32],
//          |     |        task_id[39:36]
// m_axis   | out | tdata: status[1:0], index_out[5:2], woken_valid[6],
//          |     |        woken_task[10:7], zeros[15:11]
//
// One request at a time. Acquire reads the queue record when it must wait behind
// a waiter; release reads it when the queue is nonempty, then a link read when
// the queue has more than one waiter. Open searches the stored keys: the key
// memory's single port reads one stored key per cycle during the search.
// Reset is synchronous, active low, and clears the fill count, held and
// queue-nonempty bits. A result waiting in the output register does not stop
// the next request from being taken; only loading a new result waits for it.
`timescale 1ns / 1ps
`include "mutex_table_with_wait_queues_assert.svh"

module mutex_table_with_wait_queues #(
    parameter int LOCKS = 16,
    parameter int TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // lock_key, lock_index, task_id
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status, index_out, woken_valid, woken_task
);

    localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int CW = $clog2(LOCKS + 1);
    localparam int TW = $clog2(TASKS);
    localparam logic [CW-1:0] LOCKS_CW = CW'(LOCKS);

    // head and tail of one lock's wait queue
    typedef struct packed {
        logic [TW-1:0] head;
        logic [TW-1:0] tail;
    } t_qrec;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [3:0] f_to4(input logic [31:0] v);
        return v[3:0];
    endfunction

    // task_id modulo TASKS by repeated subtraction on a 4-bit value
    function automatic logic [TW-1:0] f_task_mod(input logic [3:0] v);
        logic [3:0]  m;
        logic [31:0] e;
        m = v;
        for (int k = 0; k < 8; k++) begin
            if (32'(m) >= 32'(TASKS)) begin
                m = m - 4'(TASKS);
            end
        end
        e = 32'(m);
        return e[TW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    mtwq_pkg::t_state  r_state, n_state;

    // captured request
    logic [1:0]        r_kind;
    logic [31:0]       r_key;
    logic [3:0]        r_lidx;
    logic [TW-1:0]     r_task;

    // table bookkeeping in flops
    logic [CW-1:0]     r_used, n_used;
    logic [LOCKS-1:0]  r_held, n_held;
    logic [LOCKS-1:0]  r_nonempty, n_nonempty;

    // key search
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [LW-1:0]     r_pidx, n_pidx;

    // result and output register
    mtwq_pkg::t_result r_res, n_res;
    mtwq_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // memories and their registered read data
    logic [31:0]       r_key_mem [LOCKS];
    logic [31:0]       r_key_rd;
    logic [LW-1:0]     key_addr;
    logic              key_we;

    t_qrec             r_q_mem [LOCKS];
    t_qrec             r_q_rd;
    t_qrec             q_wdata;
    logic              q_we;

    logic [TW-1:0]     r_link_mem [TASKS];
    logic [TW-1:0]     r_link_rd;
    logic [TW-1:0]     link_raddr;
    logic [TW-1:0]     link_waddr;
    logic              link_we;

    // ------------------------------------------------------------------
    // derived conditions
    // ------------------------------------------------------------------
    logic              accept;
    logic              out_free;
    logic [31:0]       lidx_ext;
    logic [LW-1:0]     idx_w;
    logic              idx_bad;
    logic              hit;
    logic              more;
    logic              full;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign lidx_ext = 32'(r_lidx);
    assign idx_w    = lidx_ext[LW-1:0];
    assign idx_bad  = lidx_ext >= 32'(r_used);
    assign hit      = r_pend && (r_key_rd == r_key);
    assign more     = r_cnt < r_used;
    assign full     = r_used == LOCKS_CW;

    // the queue record of the current lock is read every cycle; the link
    // memory is read at the queue head
    assign link_raddr = r_q_rd.head;

    assign s_axis_tready = (r_state == mtwq_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out};

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtwq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = mtwq_pkg::S_EXEC;
                end
            end
            mtwq_pkg::S_EXEC: begin
                case (r_kind)
                    mtwq_pkg::KIND_OPEN: begin
                        n_state = mtwq_pkg::S_SEARCH;
                    end
                    mtwq_pkg::KIND_ACQUIRE: begin
                        if (!idx_bad && r_held[idx_w] && r_nonempty[idx_w]) begin
                            n_state = mtwq_pkg::S_QREAD;
                        end else begin
                            n_state = mtwq_pkg::S_DONE;
                        end
                    end
                    mtwq_pkg::KIND_RELEASE: begin
                        if (!idx_bad && r_nonempty[idx_w]) begin
                            n_state = mtwq_pkg::S_QREAD;
                        end else begin
                            n_state = mtwq_pkg::S_DONE;
                        end
                    end
                    default: begin
                        n_state = mtwq_pkg::S_DONE;
                    end
                endcase
            end
            mtwq_pkg::S_SEARCH: begin
                if (hit || !more) begin
                    n_state = mtwq_pkg::S_DONE;
                end
            end
            mtwq_pkg::S_QREAD: begin
                if ((r_kind == mtwq_pkg::KIND_RELEASE) && (r_q_rd.head != r_q_rd.tail)) begin
                    n_state = mtwq_pkg::S_LINK;
                end else begin
                    n_state = mtwq_pkg::S_DONE;
                end
            end
            mtwq_pkg::S_LINK: begin
                n_state = mtwq_pkg::S_DONE;
            end
            mtwq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mtwq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtwq_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and memory controls
    // ------------------------------------------------------------------
    always_comb begin
        n_used      = r_used;
        n_held      = r_held;
        n_nonempty  = r_nonempty;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;   // drop a taken result
        key_addr    = r_cnt[LW-1:0];
        key_we      = 1'b0;
        q_we        = 1'b0;
        q_wdata     = r_q_rd;
        link_we     = 1'b0;
        link_waddr  = r_q_rd.tail;

        case (r_state)
            mtwq_pkg::S_EXEC: begin
                n_res  = '0;
                n_cnt  = '0;
                n_pend = 1'b0;
                case (r_kind)
                    mtwq_pkg::KIND_ACQUIRE: begin
                        if (idx_bad) begin
                            n_res.status = mtwq_pkg::ST_BAD_INDEX;
                        end else if (!r_held[idx_w]) begin
                            n_held[idx_w] = 1'b1;
                        end else if (!r_nonempty[idx_w]) begin
                            // first waiter: queue holds just this task
                            q_we                = 1'b1;
                            q_wdata.head        = r_task;
                            q_wdata.tail        = r_task;
                            n_nonempty[idx_w]   = 1'b1;
                            n_res.status        = mtwq_pkg::ST_BLOCKED;
                        end else begin
                            n_res.status = mtwq_pkg::ST_BLOCKED;
                        end
                    end
                    mtwq_pkg::KIND_RELEASE: begin
                        if (idx_bad) begin
                            n_res.status = mtwq_pkg::ST_BAD_INDEX;
                        end else if (!r_nonempty[idx_w]) begin
                            n_held[idx_w] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mtwq_pkg::S_SEARCH: begin
                if (hit) begin
                    n_res.index_out = f_to4(32'(r_pidx));
                end else if (more) begin
                    // issue the next key read, compare it next cycle
                    n_pend = 1'b1;
                    n_pidx = r_cnt[LW-1:0];
                    n_cnt  = r_cnt + CW'(1);
                end else if (full) begin
                    n_res.status = mtwq_pkg::ST_FULL;
                end else begin
                    key_addr        = r_used[LW-1:0];
                    key_we          = 1'b1;
                    n_used          = r_used + CW'(1);
                    n_res.index_out = f_to4(32'(r_used));
                end
            end
            mtwq_pkg::S_QREAD: begin
                if (r_kind == mtwq_pkg::KIND_ACQUIRE) begin
                    // append behind the current tail
                    link_we      = 1'b1;
                    q_we         = 1'b1;
                    q_wdata.tail = r_task;
                end else begin
                    n_res.woken_valid = 1'b1;
                    n_res.woken_task  = f_to4(32'(r_q_rd.head));
                    if (r_q_rd.head == r_q_rd.tail) begin
                        n_nonempty[idx_w] = 1'b0;
                    end
                end
            end
            mtwq_pkg::S_LINK: begin
                // advance the head to the next waiter
                q_we         = 1'b1;
                q_wdata.head = r_link_rd;
            end
            mtwq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtwq_pkg::S_IDLE;
            r_used      <= '0;
            r_held      <= '0;
            r_nonempty  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_held      <= n_held;
            r_nonempty  <= n_nonempty;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_key  <= s_axis_tdata[31:0];
            r_lidx <= s_axis_tdata[35:32];
            r_task <= f_task_mod(s_axis_tdata[39:36]);
        end
        r_cnt  <= n_cnt;
        r_pidx <= n_pidx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // ------------------------------------------------------------------
    // memories with registered read data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_addr] <= r_key;
        end
        r_key_rd <= r_key_mem[key_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[idx_w] <= q_wdata;
        end
        r_q_rd <= r_q_mem[idx_w];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= r_task;
        end
        r_link_rd <= r_link_mem[link_raddr];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MTWQ_ASSERT_IMPL(a_used_in_range, 1'b1, r_used <= LOCKS_CW, "fill count beyond table size")
    `MTWQ_ASSERT_IMPL(a_out_from_done, $rose(r_out_valid), $past(r_state) == mtwq_pkg::S_DONE, "result loaded outside done state")
    `MTWQ_ASSERT_IMPL(a_used_step, r_used != $past(r_used), ($past(r_state) == mtwq_pkg::S_SEARCH) && (r_used == $past(r_used) + CW'(1)), "fill count moved outside allocation")
    `MTWQ_ASSERT_NEXT(a_search_keeps_locks, r_state == mtwq_pkg::S_SEARCH, $stable(r_held) && $stable(r_nonempty), "lock bits changed during key search")

endmodule

>>> test/mutex_table_with_wait_queues_tb.sv
// Self-checking testbench for the lock table with FIFO wait queues.
`timescale 1ns / 1ps

module mutex_table_with_wait_queues_tb;

    localparam int LOCK_COUNT = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 40;

    // the fourth request code does nothing but return an all-zero reply
    localparam logic [1:0] KIND_NONE = 2'd3;

    // canned replies for the directed table
    localparam mtwq_pkg::t_result R_OK      = '{4'd0, 1'b0, 4'd0, mtwq_pkg::ST_OK};
    localparam mtwq_pkg::t_result R_BLOCKED = '{4'd0, 1'b0, 4'd0, mtwq_pkg::ST_BLOCKED};
    localparam mtwq_pkg::t_result R_FULL    = '{4'd0, 1'b0, 4'd0, mtwq_pkg::ST_FULL};
    localparam mtwq_pkg::t_result R_BAD     = '{4'd0, 1'b0, 4'd0, mtwq_pkg::ST_BAD_INDEX};
    localparam mtwq_pkg::t_result R_IDX1    = '{4'd0, 1'b0, 4'd1, mtwq_pkg::ST_OK};
    localparam mtwq_pkg::t_result R_IDX2    = '{4'd0, 1'b0, 4'd2, mtwq_pkg::ST_OK};
    localparam mtwq_pkg::t_result R_IDX3    = '{4'd0, 1'b0, 4'd3, mtwq_pkg::ST_OK};
    localparam mtwq_pkg::t_result R_WOKE10  = '{4'd10, 1'b1, 4'd0, mtwq_pkg::ST_OK};

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       key;
        logic [3:0]        idx;
        logic [3:0]        tsk;
        logic [3:0]        reps;   // repeat count; the key advances by one per repeat
        logic              typed;  // 1: use the reply below, 0: ask the predictor
        mtwq_pkg::t_result want;
    } t_directed_row;

    localparam int N_DIRECTED = 22;

    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // requests on an empty table hit unallocated indexes
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_BAD},
        '{mtwq_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 4'd15, 4'd15, 4'd1,  1'b1, R_BAD},
        // unknown request code
        '{KIND_NONE,              32'hFFFF_FFFF, 4'd15, 4'd15, 4'd1,  1'b1, R_OK},
        // allocate the key extremes, then find the first one again
        '{mtwq_pkg::KIND_OPEN,    32'h8000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_OK},
        '{mtwq_pkg::KIND_OPEN,    32'h7FFF_FFFF, 4'd0,  4'd0,  4'd1,  1'b1, R_IDX1},
        '{mtwq_pkg::KIND_OPEN,    32'hFFFF_FFFF, 4'd0,  4'd0,  4'd1,  1'b1, R_IDX2},
        '{mtwq_pkg::KIND_OPEN,    32'h0000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_IDX3},
        '{mtwq_pkg::KIND_OPEN,    32'h8000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_OK},
        // grant, then queue 15, 3 and 15 again behind the holder
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_OK},
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd0,  4'd15, 4'd1,  1'b1, R_BLOCKED},
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd0,  4'd3,  4'd1,  1'b1, R_BLOCKED},
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd0,  4'd15, 4'd1,  1'b1, R_BLOCKED},
        // task 15 is now head and tail, so one release empties the queue; then free
        '{mtwq_pkg::KIND_RELEASE, 32'h0000_0000, 4'd0,  4'd0,  4'd4,  1'b0, R_OK},
        // releasing a lock that is already free, then acquiring an unallocated index
        '{mtwq_pkg::KIND_RELEASE, 32'h0000_0000, 4'd0,  4'd0,  4'd1,  1'b1, R_OK},
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd4,  4'd9,  4'd1,  1'b1, R_BAD},
        // fill the rest of the table, then overflow it
        '{mtwq_pkg::KIND_OPEN,    32'h0000_1000, 4'd0,  4'd0,  4'd12, 1'b0, R_OK},
        '{mtwq_pkg::KIND_OPEN,    32'h5A5A_5A5A, 4'd0,  4'd0,  4'd1,  1'b1, R_FULL},
        '{mtwq_pkg::KIND_OPEN,    32'h7FFF_FFFF, 4'd0,  4'd0,  4'd1,  1'b1, R_IDX1},
        // top index: grant, block, hand over, free
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd15, 4'd0,  4'd1,  1'b1, R_OK},
        '{mtwq_pkg::KIND_ACQUIRE, 32'h0000_0000, 4'd15, 4'd10, 4'd1,  1'b1, R_BLOCKED},
        '{mtwq_pkg::KIND_RELEASE, 32'h0000_0000, 4'd15, 4'd0,  4'd1,  1'b1, R_WOKE10},
        '{mtwq_pkg::KIND_RELEASE, 32'h0000_0000, 4'd15, 4'd0,  4'd1,  1'b1, R_OK}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // lock_key[31:0], lock_index[35:32], task_id[39:36]
    logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[1:0], index_out[5:2], woken_valid[6],
                                      // woken_task[10:7], zeros[15:11]

    // predicted lock table
    logic [31:0] lock_keys [LOCK_COUNT];
    int          keys_used = 0;
    logic        lock_held [LOCK_COUNT];
    logic [3:0]  wait_head [LOCK_COUNT];
    logic [3:0]  wait_tail [LOCK_COUNT];
    logic        wait_busy [LOCK_COUNT];
    logic [3:0]  waiter_link [16];
    logic        waiter_link_set [16];   // link entries that hold a written value

    mtwq_pkg::t_result lock_replies_due [$];
    int          mismatch_count = 0;
    int          src_idle_pct = 7;
    int          snk_idle_pct = 66;

    mutex_table_with_wait_queues uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10;
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
    end

    // Work out the reply to one accepted request and advance the predicted table.
    function automatic mtwq_pkg::t_result lock_table_step(input logic [1:0] kind,
                                                          input logic [31:0] key,
                                                          input logic [3:0] idx,
                                                          input logic [3:0] tsk);
        mtwq_pkg::t_result r;
        logic       found;
        logic [3:0] w;
        r = '0;
        found = 1'b0;
        if (kind == mtwq_pkg::KIND_OPEN) begin
            // search the allocated keys in order, first match wins
            for (int i = 0; i < keys_used; i++) begin
                if (!found && lock_keys[i] == key) begin
                    found = 1'b1;
                    r.index_out = i[3:0];
                end
            end
            if (!found) begin
                if (keys_used < LOCK_COUNT) begin
                    lock_keys[keys_used] = key;
                    r.index_out = keys_used[3:0];
                    keys_used++;
                end else begin
                    r.status = mtwq_pkg::ST_FULL;
                end
            end
        end else if (kind == mtwq_pkg::KIND_ACQUIRE || kind == mtwq_pkg::KIND_RELEASE) begin
            if (idx >= keys_used) begin
                r.status = mtwq_pkg::ST_BAD_INDEX;
            end else if (kind == mtwq_pkg::KIND_ACQUIRE) begin
                if (!lock_held[idx]) begin
                    lock_held[idx] = 1'b1;
                end else begin
                    // append the task behind the current tail
                    if (wait_busy[idx]) begin
                        waiter_link[wait_tail[idx]] = tsk;
                        waiter_link_set[wait_tail[idx]] = 1'b1;
                    end else begin
                        wait_head[idx] = tsk;
                        wait_busy[idx] = 1'b1;
                    end
                    wait_tail[idx] = tsk;
                    r.status = mtwq_pkg::ST_BLOCKED;
                end
            end else if (!wait_busy[idx]) begin
                lock_held[idx] = 1'b0;
            end else begin
                // pop the oldest waiter; the lock stays held
                w = wait_head[idx];
                if (w == wait_tail[idx]) begin
                    wait_busy[idx] = 1'b0;
                end else begin
                    wait_head[idx] = waiter_link[w];
                end
                r.woken_valid = 1'b1;
                r.woken_task = w;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Present one request after a random idle stretch; hold it until the transfer.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                                input logic [3:0] idx, input logic [3:0] tsk,
                                input logic typed, input mtwq_pkg::t_result want);
        mtwq_pkg::t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {tsk, idx, key};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = lock_table_step(kind, key, idx, tsk);
        lock_replies_due.push_back(typed ? want : predicted);
    endtask

    // Compare each reply transfer with the oldest expectation; stall the output at random.
    always @(posedge i_clk) begin
        mtwq_pkg::t_result got;
        mtwq_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = mtwq_pkg::t_result'(m_axis_tdata[10:0]);
            if (lock_replies_due.size() == 0) begin
                note_failure($sformatf("reply %h with nothing expected", got));
            end else begin
                want = lock_replies_due.pop_front();
                if (got.status !== want.status || got.index_out !== want.index_out ||
                    got.woken_valid !== want.woken_valid ||
                    got.woken_task !== want.woken_task) begin
                    note_failure($sformatf(
                        "status %0d/%0d index %0d/%0d woken_valid %0d/%0d woken %0d/%0d (exp/got)",
                        want.status, got.status, want.index_out, got.index_out,
                        want.woken_valid, got.woken_valid, want.woken_task, got.woken_task));
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        logic [1:0]  kind;
        logic [31:0] key;
        logic [3:0]  idx;
        logic [3:0]  tsk;
        int unsigned pick;
        for (int i = 0; i < LOCK_COUNT; i++) begin
            lock_held[i] = 1'b0;
            wait_busy[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
            waiter_link_set[i] = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                send_request(DIRECTED[r].kind, DIRECTED[r].key + k, DIRECTED[r].idx,
                             DIRECTED[r].tsk, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // random traffic, mostly on a few locks so that wait queues grow deep
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                src_idle_pct = 66;
                snk_idle_pct = 7;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick = $urandom_range(99);
            key = $urandom;
            tsk = 4'($urandom_range(15));
            if ($urandom_range(99) < 70) begin
                idx = 4'($urandom_range(3));
            end else begin
                idx = 4'($urandom_range(15));
            end
            if (pick < 15) begin
                kind = mtwq_pkg::KIND_OPEN;
                if (keys_used > 0 && $urandom_range(1) == 1) begin
                    key = lock_keys[$urandom_range(keys_used - 1)];
                end
            end else if (pick < 57) begin
                kind = mtwq_pkg::KIND_ACQUIRE;
            end else if (pick < 96) begin
                kind = mtwq_pkg::KIND_RELEASE;
            end else begin
                kind = KIND_NONE;
            end
            // A task queued on two locks can leave a queue head whose link was never
            // written; turn such a release into an acquire instead.
            if (kind == mtwq_pkg::KIND_RELEASE && idx < keys_used && wait_busy[idx] &&
                wait_head[idx] != wait_tail[idx] && !waiter_link_set[wait_head[idx]]) begin
                kind = mtwq_pkg::KIND_ACQUIRE;
            end
            send_request(kind, key, idx, tsk, 1'b0, R_OK);
        end
        s_axis_tvalid <= 1'b0;

        // drain the outstanding replies, then watch for stray ones
        while (lock_replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && lock_replies_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
